FILE: design/serial_mouse_packet_decoder_macros.svh
// Assertion macros for the serial mouse packet decoder.
`ifndef SERIAL_MOUSE_PACKET_DECODER_MACROS_SVH
`define SERIAL_MOUSE_PACKET_DECODER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset
`define SMPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("serial mouse decoder check failed");
// Next-cycle implication, sampled on clk, off during reset
`define SMPD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("serial mouse decoder check failed");
`else
`define SMPD_ASSERT_IMP(lbl, ante, cons)
`define SMPD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: design/smpd_pkg.sv
// Shared types and constants for the serial mouse packet decoder.
`default_nettype none

package smpd_pkg;

	// stream widths
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 32;

	// status codes
	localparam logic ST_PACKET   = 1'b0;
	localparam logic ST_SYNC_ERR = 1'b1;

	// packet lengths
	localparam logic [2:0] PKT_LEN_NONE = 3'd0;
	localparam logic [2:0] PKT_LEN3     = 3'd3;
	localparam logic [2:0] PKT_LEN4     = 3'd4;

	// event codes
	localparam logic [3:0] EV_LEFT_UP   = 4'd0;
	localparam logic [3:0] EV_LEFT_DN   = 4'd1;
	localparam logic [3:0] EV_MID_UP    = 4'd2;
	localparam logic [3:0] EV_MID_DN    = 4'd3;
	localparam logic [3:0] EV_RIGHT_UP  = 4'd4;
	localparam logic [3:0] EV_RIGHT_DN  = 4'd5;
	localparam logic [3:0] EV_MID2_UP   = 4'd6;
	localparam logic [3:0] EV_MID2_DN   = 4'd7;
	localparam logic [3:0] EV_MOTION    = 4'd8;
	localparam logic [3:0] EV_NONE      = 4'd9;

	// byte bit positions
	localparam int unsigned HDR_BIT   = 6;
	localparam int unsigned BTN_A_BIT = 5;  // left in byte 0, middle in byte 3
	localparam int unsigned BTN_B_BIT = 4;  // right in byte 0, middle2 in byte 3

	// packet close request from the sync logic to the formatter
	typedef struct packed {
		logic       emit;
		logic       sync_err;
		logic [2:0] nbytes;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] fourth;
	} smpd_req_t;

	// one result item
	typedef struct packed {
		logic              status;
		logic [2:0]        packet_bytes;
		logic [3:0]        buttons;
		logic signed [7:0] delta_x;
		logic signed [7:0] delta_y;
		logic [3:0]        event_res;
	} smpd_res_t;

endpackage

`default_nettype wire

FILE: design/smpd_sync_fsm.sv
// Header sync and byte collection for the serial mouse packet decoder.
`default_nettype none

module smpd_sync_fsm
	import smpd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,      // current item is consumed this cycle
	input  wire logic       idle,      // item is an idle tick
	input  wire logic [7:0] rx_byte,
	output smpd_req_t       req
);

	typedef enum logic [1:0] {
		WAIT_HDR,
		GET_B1,
		GET_B2,
		HAVE3
	} phase_t;

	phase_t     phase_q;
	logic [7:0] b0_q, b1_q, b2_q;
	logic       hdr;

	assign hdr = rx_byte[HDR_BIT];

	// close request for the current item
	always_comb begin
		req.emit     = 1'b0;
		req.sync_err = 1'b0;
		req.nbytes   = PKT_LEN3;
		req.b0       = b0_q;
		req.b1       = b1_q;
		req.b2       = b2_q;
		req.fourth   = 8'd0;
		case (phase_q)
			HAVE3: begin
				req.emit = 1'b1;
				if (!idle && !hdr) begin
					req.nbytes = PKT_LEN4;
					req.fourth = rx_byte;
				end
			end
			WAIT_HDR: begin
				if (!idle && !hdr) begin
					req.emit     = 1'b1;
					req.sync_err = 1'b1;
					req.nbytes   = PKT_LEN_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	// phase and held bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= WAIT_HDR;
			b0_q    <= 8'd0;
			b1_q    <= 8'd0;
			b2_q    <= 8'd0;
		end else if (fire) begin
			case (phase_q)
				GET_B1: begin
					if (!idle) begin
						b1_q    <= rx_byte;
						phase_q <= GET_B2;
					end
				end
				GET_B2: begin
					if (!idle) begin
						b2_q    <= rx_byte;
						phase_q <= HAVE3;
					end
				end
				HAVE3: begin
					if (!idle && hdr) begin
						b0_q    <= rx_byte;
						phase_q <= GET_B1;
					end else begin
						phase_q <= WAIT_HDR;
					end
				end
				default: begin
					if (!idle && hdr) begin
						b0_q    <= rx_byte;
						phase_q <= GET_B1;
					end else begin
						phase_q <= WAIT_HDR;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/smpd_pkt_fmt.sv
// Button, motion and event decode for a closed serial mouse packet.
`default_nettype none

module smpd_pkt_fmt
	import smpd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire smpd_req_t req,
	output smpd_res_t      res
);

	logic [3:0] prev_btn_q;
	logic [3:0] now_btn;
	logic [3:0] changed;
	logic [7:0] dx, dy;
	logic [3:0] ev;

	// motion: top two bits from the header byte
	assign dx = {req.b0[1:0], req.b1[5:0]};
	assign dy = {req.b0[3:2], req.b2[5:0]};

	// bit0 left, bit1 middle, bit2 right, bit3 middle2
	assign now_btn = {req.fourth[BTN_B_BIT], req.b0[BTN_B_BIT],
	                  req.fourth[BTN_A_BIT], req.b0[BTN_A_BIT]};
	assign changed = prev_btn_q ^ now_btn;

	// event priority: left, middle, middle2, right, then motion
	always_comb begin
		if (changed[0])
			ev = now_btn[0] ? EV_LEFT_DN : EV_LEFT_UP;
		else if (changed[1])
			ev = now_btn[1] ? EV_MID_DN : EV_MID_UP;
		else if (changed[3])
			ev = now_btn[3] ? EV_MID2_DN : EV_MID2_UP;
		else if (changed[2])
			ev = now_btn[2] ? EV_RIGHT_DN : EV_RIGHT_UP;
		else if (dx != 8'd0 || dy != 8'd0)
			ev = EV_MOTION;
		else
			ev = EV_NONE;
	end

	// result fields; a sync error carries only its status
	always_comb begin
		if (req.sync_err) begin
			res.status       = ST_SYNC_ERR;
			res.packet_bytes = PKT_LEN_NONE;
			res.buttons      = 4'd0;
			res.delta_x      = 8'sd0;
			res.delta_y      = 8'sd0;
			res.event_res    = EV_NONE;
		end else begin
			res.status       = ST_PACKET;
			res.packet_bytes = req.nbytes;
			res.buttons      = now_btn;
			res.delta_x      = dx;
			res.delta_y      = dy;
			res.event_res    = ev;
		end
	end

	// button state of the last decoded packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_btn_q <= 4'd0;
		end else if (fire && req.emit && !req.sync_err) begin
			prev_btn_q <= now_btn;
		end
	end

endmodule

`default_nettype wire

FILE: design/serial_mouse_packet_decoder.sv
// A result passes the input register, then the decode logic, into the result register.
// Throughput: one input transaction per cycle while m_axis is not stalled, set by the single input
// register feeding one level of decode logic into the result register.
// Reset (arst_n low, asynchronous): waits for a header, all buttons up,
// both stages empty.
`default_nettype none
`include "serial_mouse_packet_decoder_macros.svh"

module serial_mouse_packet_decoder
	import smpd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
	input  wire logic                  s_axis_tuser,   // [0] idle tick
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [2:0] packet_bytes, [6:3] buttons,
	                                                   // [14:7] delta_x, [22:15] delta_y,
	                                                   // [26:23] event_res, [31:27] zero
	output logic                       m_axis_tuser    // [0] status
);

	logic       in_valid_s1;
	logic       idle_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       out_valid_q;
	smpd_req_t  req;
	smpd_res_t  res;
	smpd_res_t  res_q;

	// input stage moves on when the result slot is free or draining
	assign adv           = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			idle_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	smpd_sync_fsm u_sync (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.idle    (idle_s1),
		.rx_byte (byte_s1),
		.req     (req)
	);

	smpd_pkt_fmt u_fmt (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.req    (req),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && req.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && req.emit) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.status;
	assign m_axis_tdata  = {5'd0, res_q.event_res, res_q.delta_y, res_q.delta_x,
	                        res_q.buttons, res_q.packet_bytes};

	// checks
	`SMPD_ASSERT_IMP(a_sync_err_empty, out_valid_q && res_q.status == ST_SYNC_ERR, res_q.packet_bytes == PKT_LEN_NONE && res_q.event_res == EV_NONE)
	`SMPD_ASSERT_IMP(a_pkt_len, out_valid_q && res_q.status == ST_PACKET, res_q.packet_bytes == PKT_LEN3 || res_q.packet_bytes == PKT_LEN4)
	`SMPD_ASSERT_NXT(a_in_held, in_valid_s1 && !adv, in_valid_s1)
	`SMPD_ASSERT_IMP(a_ready_when_empty, !out_valid_q, s_axis_tready)

endmodule

`default_nettype wire
